// ===== rtl/apm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Audio level meter package
// Shared widths, register indexes, reset values and types for the meter.
// ----------------------------------------------------------------------------
package apm_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int LEVEL_W   = 24;
    localparam int COUNT_W   = 20;
    localparam int MS_W      = 47;
    localparam int FACTOR_W  = 24;
    localparam int CH_W      = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 24;

    localparam int CHANNELS_DEFAULT = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RMS_ALPHA    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_SAMPLES = 2'd2;

    localparam logic [FACTOR_W-1:0] DECAY_FACTOR_RST = 24'd16776411;
    localparam logic [FACTOR_W-1:0] RMS_ALPHA_RST    = 24'd1165;
    localparam logic [COUNT_W-1:0]  HOLD_SAMPLES_RST = 20'd72000;

    // One channel's stored levels, kept as one memory word.
    typedef struct packed {
        logic [LEVEL_W-1:0] peak;
        logic [LEVEL_W-1:0] hold;
        logic [COUNT_W-1:0] count;
        logic [MS_W-1:0]    ms;
    } t_chan_state;

    // Stage strobes from the sequencer to the update datapath.
    typedef struct packed {
        logic load;
        logic diff;
        logic mul;
        logic sum;
    } t_stage_ctrl;

endpackage

// ===== rtl/audio_peak_hold_rms_meter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Audio peak, peak-hold and mean-square level meter
// Per-channel level tracking with a decaying peak, a held peak and a
// one-pole smoothed mean of squared samples, kept in one channel memory.
// ----------------------------------------------------------------------------
// Usage:
// A sample transfer on the input channel (i_in_valid high, o_in_stall low)
// carries a channel number and a signed 24-bit sample. The block reads that
// channel's word from the state memory, updates it and writes it back, and
// presents the new levels on the output channel, held until the receiver
// takes the transfer (o_out_valid high, i_out_stall low).
// One item is worked on at a time: the input is taken in the idle state,
// and the result is shown after the load, difference, multiply, sum and
// write-back states, before the next is taken. The path is the memory read,
// the decay and square multiplies, the mean-square difference, the weight
// multiplies, the step sum and the write-back. If the previous result is
// still stalled at write-back, the block waits there and stalls its input.
// A sample for a channel at or beyond CHANNELS is taken and dropped.
// Reset clears every channel's levels at once through per-channel valid bits
// and loads the register reset values. The user must write registers through
// the plain write port while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module audio_peak_hold_rms_meter #(
    parameter int CHANNELS = apm_pkg::CHANNELS_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration port
    input  logic                             i_cfg_we,
    input  logic [apm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [apm_pkg::CFG_W-1:0]        i_cfg_data,
    // Sample input
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [apm_pkg::CH_W-1:0]         i_channel,
    input  logic signed [apm_pkg::SAMPLE_W-1:0] i_sample,
    // Level output
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [apm_pkg::CH_W-1:0]         o_out_channel,
    output logic [apm_pkg::LEVEL_W-1:0]      o_peak_level,
    output logic [apm_pkg::LEVEL_W-1:0]      o_held_peak,
    output logic [apm_pkg::MS_W-1:0]         o_mean_square
);

    import apm_pkg::*;

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SW = $bits(t_chan_state);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_DIFF = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_SUM  = 3'd4;
    localparam logic [2:0] S_WB   = 3'd5;

    logic [2:0]            r_state;
    logic [2:0]            n_state;
    logic [FACTOR_W-1:0]   r_decay;
    logic [FACTOR_W-1:0]   r_alpha;
    logic [COUNT_W-1:0]    r_hold_samples;
    logic [CHANNELS-1:0]   r_valid;
    logic [CH_W-1:0]       r_ch;
    logic [AW-1:0]         r_addr;
    logic [LEVEL_W-1:0]    r_mag;
    logic                  r_out_valid;
    logic [CH_W-1:0]       r_out_channel;
    logic [LEVEL_W-1:0]    r_out_peak;
    logic [LEVEL_W-1:0]    r_out_hold;
    logic [MS_W-1:0]       r_out_ms;

    logic                  in_xfer;
    logic                  in_range;
    logic [AW+CH_W-1:0]    ch_ext;
    logic [AW-1:0]         in_addr;
    logic [LEVEL_W-1:0]    in_mag;
    logic                  out_free;
    logic                  wb_go;
    logic [SW-1:0]         ram_rdata;
    t_chan_state           rd_state;
    t_chan_state           next_state;
    t_stage_ctrl           ctrl;

    // The input is only taken in the idle state; one item is in flight.
    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign in_range   = int'(i_channel) < CHANNELS;
    assign ch_ext     = {{AW{1'b0}}, i_channel};
    assign in_addr    = ch_ext[AW-1:0];

    // Magnitude of a 24-bit sample; full-scale negative maps to 2^23.
    assign in_mag = i_sample[SAMPLE_W-1] ? (~i_sample + 1'b1) : i_sample;

    assign out_free = !r_out_valid || !i_out_stall;
    assign wb_go    = (r_state == S_WB) && out_free;

    always_comb begin
        ctrl.load = (r_state == S_LOAD);
        ctrl.diff = (r_state == S_DIFF);
        ctrl.mul  = (r_state == S_MUL);
        ctrl.sum  = (r_state == S_SUM);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer && in_range) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD:  n_state = S_DIFF;
            S_DIFF:  n_state = S_MUL;
            S_MUL:   n_state = S_SUM;
            S_SUM:   n_state = S_WB;
            S_WB: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_decay        <= DECAY_FACTOR_RST;
            r_alpha        <= RMS_ALPHA_RST;
            r_hold_samples <= HOLD_SAMPLES_RST;
            r_valid        <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DECAY_FACTOR: r_decay        <= i_cfg_data[FACTOR_W-1:0];
                    CFG_RMS_ALPHA:    r_alpha        <= i_cfg_data[FACTOR_W-1:0];
                    CFG_HOLD_SAMPLES: r_hold_samples <= i_cfg_data[COUNT_W-1:0];
                    default:          ;
                endcase
            end
            if (wb_go) begin
                r_valid[r_addr] <= 1'b1;
                r_out_valid     <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_ch   <= i_channel;
            r_addr <= in_addr;
            r_mag  <= in_mag;
        end
        if (wb_go) begin
            r_out_channel <= r_ch;
            r_out_peak    <= next_state.peak;
            r_out_hold    <= next_state.hold;
            r_out_ms      <= next_state.ms;
        end
    end

    apm_ram #(
        .WIDTH (SW),
        .DEPTH (CHANNELS),
        .AW    (AW)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (wb_go),
        .i_waddr (r_addr),
        .i_wdata (next_state),
        .i_re    (in_xfer),
        .i_raddr (in_addr),
        .o_rdata (ram_rdata)
    );

    // A channel never written since reset reads as all zero.
    assign rd_state = r_valid[r_addr] ? t_chan_state'(ram_rdata) : '0;

    apm_update u_update (
        .i_clk          (i_clk),
        .i_ctrl         (ctrl),
        .i_state        (rd_state),
        .i_mag          (r_mag),
        .i_decay        (r_decay),
        .i_alpha        (r_alpha),
        .i_hold_samples (r_hold_samples),
        .o_next         (next_state)
    );

    assign o_out_valid   = r_out_valid;
    assign o_out_channel = r_out_channel;
    assign o_peak_level  = r_out_peak;
    assign o_held_peak   = r_out_hold;
    assign o_mean_square = r_out_ms;

    // Magnitudes never exceed full scale, and the mean square never exceeds
    // the largest square.
    a_levels_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_peak_level <= 24'h800000) && (o_held_peak <= 24'h800000))
        else $error("level above full scale");

    a_ms_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_mean_square <= 47'h400000000000))
        else $error("mean square above full scale squared");

    // A write-back always returns the sequencer to idle with a result shown.
    a_wb_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wb_go |=> (r_state == S_IDLE) && o_out_valid)
        else $error("write-back did not complete");

    // Between input transfer and write-back the input stays stalled.
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && in_range) |=> o_in_stall)
        else $error("input taken while an item is in flight");

endmodule

// ===== rtl/apm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module apm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/apm_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Audio level meter update datapath
// Computes one channel's new peak, held peak, countdown and mean square
// over four registered stages.
// ----------------------------------------------------------------------------
module apm_update (
    input  logic                                i_clk,
    input  apm_pkg::t_stage_ctrl                i_ctrl,
    input  apm_pkg::t_chan_state                i_state,
    input  logic [apm_pkg::LEVEL_W-1:0]         i_mag,
    input  logic [apm_pkg::FACTOR_W-1:0]        i_decay,
    input  logic [apm_pkg::FACTOR_W-1:0]        i_alpha,
    input  logic [apm_pkg::COUNT_W-1:0]         i_hold_samples,
    output apm_pkg::t_chan_state                o_next
);

    import apm_pkg::*;

    localparam int PROD_W = LEVEL_W + FACTOR_W;
    localparam int HI_W   = MS_W - FACTOR_W;

    logic [PROD_W-1:0]   sq_full;
    logic [PROD_W-1:0]   peak_prod;
    logic [PROD_W-1:0]   hold_prod;
    logic [LEVEL_W-1:0]  peak_dec;
    logic [LEVEL_W-1:0]  hold_dec;
    logic                neg;
    logic [MS_W-1:0]     diff;
    logic [MS_W:0]       q_sum;

    t_chan_state         r_old;
    logic [MS_W-1:0]     r_sq;
    logic [PROD_W-1:0]   r_peak_prod;
    logic [PROD_W-1:0]   r_hold_prod;
    logic [LEVEL_W-1:0]  r_new_peak;
    logic [LEVEL_W-1:0]  r_new_hold;
    logic [COUNT_W-1:0]  r_new_count;
    logic                r_neg;
    logic [HI_W-1:0]     r_hi;
    logic [FACTOR_W-1:0] r_lo;
    logic [MS_W-1:0]     r_hi_prod;
    logic [PROD_W-1:0]   r_lo_prod;
    logic [MS_W-1:0]     r_q;

    assign sq_full   = i_mag * i_mag;
    assign peak_prod = i_state.peak * i_decay;
    assign hold_prod = i_state.hold * i_decay;

    assign peak_dec = r_peak_prod[PROD_W-1:FACTOR_W];
    assign hold_dec = r_hold_prod[PROD_W-1:FACTOR_W];
    assign neg      = r_sq < r_old.ms;
    assign diff     = neg ? (r_old.ms - r_sq) : (r_sq - r_old.ms);

    // The correction makes the negative step round toward minus infinity.
    assign q_sum = {1'b0, r_hi_prod}
                 + {{(MS_W + 1 - (PROD_W - FACTOR_W)){1'b0}}, r_lo_prod[PROD_W-1:FACTOR_W]}
                 + {{MS_W{1'b0}}, (r_neg && (r_lo_prod[FACTOR_W-1:0] != '0))};

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_old       <= i_state;
            r_sq        <= sq_full[MS_W-1:0];
            r_peak_prod <= peak_prod;
            r_hold_prod <= hold_prod;
        end
        if (i_ctrl.diff) begin
            r_new_peak <= (i_mag > peak_dec) ? i_mag : peak_dec;
            if (i_mag > r_old.hold) begin
                r_new_hold  <= i_mag;
                r_new_count <= i_hold_samples;
            end else if (r_old.count != '0) begin
                r_new_hold  <= r_old.hold;
                r_new_count <= r_old.count - 1'b1;
            end else begin
                r_new_hold  <= hold_dec;
                r_new_count <= r_old.count;
            end
            r_neg <= neg;
            r_hi  <= diff[MS_W-1:FACTOR_W];
            r_lo  <= diff[FACTOR_W-1:0];
        end
        if (i_ctrl.mul) begin
            r_hi_prod <= i_alpha * r_hi;
            r_lo_prod <= i_alpha * r_lo;
        end
        if (i_ctrl.sum) begin
            r_q <= q_sum[MS_W-1:0];
        end
    end

    always_comb begin
        o_next.peak  = r_new_peak;
        o_next.hold  = r_new_hold;
        o_next.count = r_new_count;
        o_next.ms    = r_neg ? (r_old.ms - r_q) : (r_old.ms + r_q);
    end

endmodule

// ===== tb/apm_level_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Level meter result checker
// Follows the register port and both sample channels. Each input transfer
// advances a local copy of the channel levels, and each output transfer is
// compared field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module apm_level_checker
    import apm_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [CH_W-1:0]      i_channel,
    input  logic [SAMPLE_W-1:0]  i_sample,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [CH_W-1:0]      i_out_channel,
    input  logic [LEVEL_W-1:0]   i_peak_level,
    input  logic [LEVEL_W-1:0]   i_held_peak,
    input  logic [MS_W-1:0]      i_mean_square,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_results
);

    typedef struct packed {
        logic [CH_W-1:0]    ch;
        logic [LEVEL_W-1:0] peak;
        logic [LEVEL_W-1:0] hold;
        logic [MS_W-1:0]    ms;
    } t_levels;

    logic [FACTOR_W-1:0] decay_q24;
    logic [FACTOR_W-1:0] alpha_q24;
    logic [COUNT_W-1:0]  hold_len;

    logic [LEVEL_W-1:0]  peak_mem  [CHANNELS];
    logic [LEVEL_W-1:0]  hold_mem  [CHANNELS];
    logic [COUNT_W-1:0]  count_mem [CHANNELS];
    logic [MS_W-1:0]     ms_mem    [CHANNELS];

    t_levels levels_due[$];
    int      mismatches;
    int      results_seen;

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] level mismatch: %s", $realtime, msg);
    endtask

    // Q0.24 decay, product truncated.
    function automatic logic [LEVEL_W-1:0] decayed(input logic [LEVEL_W-1:0] v);
        logic [LEVEL_W+FACTOR_W-1:0] prod;
        prod = v * decay_q24;
        return prod[LEVEL_W+FACTOR_W-1:FACTOR_W];
    endfunction

    // One-pole step; the arithmetic shift floors toward minus infinity.
    function automatic logic [MS_W-1:0] smoothed(input logic [MS_W-1:0] ms,
                                                 input logic [MS_W-1:0] sq);
        logic signed [MS_W+1:0]          diff;
        logic signed [MS_W+FACTOR_W+2:0] step;
        logic signed [MS_W+FACTOR_W+2:0] sum;
        diff = $signed({2'b00, sq}) - $signed({2'b00, ms});
        step = diff * $signed({1'b0, alpha_q24});
        sum  = $signed({{(FACTOR_W+3){1'b0}}, ms}) + (step >>> FACTOR_W);
        return sum[MS_W-1:0];
    endfunction

    function automatic t_levels advance_channel(input logic [CH_W-1:0] ch,
                                                input logic [SAMPLE_W-1:0] smp);
        logic [LEVEL_W-1:0]   mag;
        logic [LEVEL_W-1:0]   peak;
        logic [LEVEL_W-1:0]   hold;
        logic [COUNT_W-1:0]   cnt;
        logic [2*LEVEL_W-1:0] sq;
        t_levels              lv;
        // The most negative sample maps to 2^23, which still fits 24 bits.
        mag  = smp[SAMPLE_W-1] ? LEVEL_W'(~smp + 1'b1) : smp;
        sq   = mag * mag;
        peak = decayed(peak_mem[ch]);
        if (mag > peak) begin
            peak = mag;
        end
        hold = hold_mem[ch];
        cnt  = count_mem[ch];
        if (mag > hold) begin
            hold = mag;
            cnt  = hold_len;
        end else if (cnt != '0) begin
            cnt = cnt - 1'b1;
        end else begin
            hold = decayed(hold);
        end
        peak_mem[ch]  = peak;
        hold_mem[ch]  = hold;
        count_mem[ch] = cnt;
        ms_mem[ch]    = smoothed(ms_mem[ch], sq[MS_W-1:0]);
        lv.ch   = ch;
        lv.peak = peak;
        lv.hold = hold;
        lv.ms   = ms_mem[ch];
        return lv;
    endfunction

    always @(posedge i_clk) begin : watch
        t_levels due;
        if (!i_rst_n) begin
            decay_q24 = DECAY_FACTOR_RST;
            alpha_q24 = RMS_ALPHA_RST;
            hold_len  = HOLD_SAMPLES_RST;
            for (int c = 0; c < CHANNELS; c++) begin
                peak_mem[c]  = '0;
                hold_mem[c]  = '0;
                count_mem[c] = '0;
                ms_mem[c]    = '0;
            end
            levels_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DECAY_FACTOR: decay_q24 = i_cfg_data[FACTOR_W-1:0];
                    CFG_RMS_ALPHA:    alpha_q24 = i_cfg_data[FACTOR_W-1:0];
                    CFG_HOLD_SAMPLES: hold_len  = i_cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                results_seen++;
                if (levels_due.size() == 0) begin
                    report_mismatch($sformatf("result for channel %0d with no sample pending",
                                              i_out_channel));
                end else begin
                    due = levels_due.pop_front();
                    if (i_out_channel !== due.ch) begin
                        report_mismatch($sformatf("out_channel got %0d expected %0d",
                                                  i_out_channel, due.ch));
                    end
                    if (i_peak_level !== due.peak) begin
                        report_mismatch($sformatf("ch %0d peak_level got %0d expected %0d",
                                                  due.ch, i_peak_level, due.peak));
                    end
                    if (i_held_peak !== due.hold) begin
                        report_mismatch($sformatf("ch %0d held_peak got %0d expected %0d",
                                                  due.ch, i_held_peak, due.hold));
                    end
                    if (i_mean_square !== due.ms) begin
                        report_mismatch($sformatf("ch %0d mean_square got %0d expected %0d",
                                                  due.ch, i_mean_square, due.ms));
                    end
                end
            end
            // Samples for channels the block does not have are dropped.
            if (i_in_valid && !i_in_stall && i_channel < CHANNELS) begin
                levels_due.push_back(advance_channel(i_channel, i_sample));
            end
        end
        o_pending    <= levels_due.size();
        o_fail_count <= mismatches;
        o_results    <= results_seen;
    end

endmodule

// ===== tb/tb_audio_peak_hold_rms_meter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Audio level meter testbench
// Drives sample transfers and register writes into the meter, with random
// gaps on the input side and random stalls on the output side. A separate
// checker predicts the per-channel levels and counts mismatches; this top
// only makes stimulus and reports the outcome.
// ----------------------------------------------------------------------------
module tb_audio_peak_hold_rms_meter;
    import apm_pkg::*;

    localparam int CHANNELS        = CHANNELS_DEFAULT;
    localparam int PHASES          = 8;
    localparam int PHASE_ITEMS     = 160;
    localparam int MAX_WAIT        = 19;
    localparam int HOLD_OFF_CYCLES = 300;
    // Margin waited out after the checker shows no result pending.
    localparam int DRAIN_CYCLES    = 12;
    localparam int CYCLE_LIMIT     = 500000;

    // Index 3 is not a register; writes to it must leave every level alone.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic [SAMPLE_W-1:0] FULL_POS = 24'h7FFFFF;
    localparam logic [SAMPLE_W-1:0] FULL_NEG = 24'h800000;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [CFG_IDX_W-1:0]       i_cfg_index;
    logic [CFG_W-1:0]           i_cfg_data;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic [CH_W-1:0]            i_channel;
    logic signed [SAMPLE_W-1:0] i_sample;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic [CH_W-1:0]            o_out_channel;
    logic [LEVEL_W-1:0]         o_peak_level;
    logic [LEVEL_W-1:0]         o_held_peak;
    logic [MS_W-1:0]            o_mean_square;

    int fail_count;
    int pending;
    int results;

    // Shared between the stimulus process and the output-side process.
    bit quiet;
    bit hold_off_req;

    int samples_sent;
    int reg_writes;
    logic [LEVEL_W-1:0] last_mag [CHANNELS];

    audio_peak_hold_rms_meter #(
        .CHANNELS(CHANNELS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_channel     (i_channel),
        .i_sample      (i_sample),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_channel (o_out_channel),
        .o_peak_level  (o_peak_level),
        .o_held_peak   (o_held_peak),
        .o_mean_square (o_mean_square)
    );

    apm_level_checker #(
        .CHANNELS(CHANNELS)
    ) level_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_channel     (i_channel),
        .i_sample      (i_sample),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out_channel (o_out_channel),
        .i_peak_level  (o_peak_level),
        .i_held_peak   (o_held_peak),
        .i_mean_square (o_mean_square),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_results     (results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs or a result never arrives.
    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("audio_peak_hold_rms_meter test failed");
        $finish;
    end

    // Presents one sample and holds it until the block takes the transfer.
    // A gap of zero keeps valid high straight into the next sample.
    task automatic send_sample(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] smp);
        int gap;
        i_in_valid <= 1'b1;
        i_channel  <= ch;
        i_sample   <= smp;
        do @(posedge i_clk); while (o_in_stall);
        samples_sent++;
        last_mag[ch] = smp[SAMPLE_W-1] ? LEVEL_W'(~smp + 1'b1) : smp;
        gap = quiet ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Write enable is dropped between writes so that it never
    // sees two assignments in one time step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        reg_writes++;
    endtask

    // Registers may only change with nothing in flight. The checker's count is
    // registered, so the first edge is taken before it is trusted.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Output side: a random stall before every result when not quiet, plus the
    // long hold-off when the stimulus asks for one. The hold-off lets the block
    // fill up so that it has to stall its input while samples keep coming.
    initial begin : take_results
        int w;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            w = quiet ? 0 : $urandom_range(0, MAX_WAIT);
            if (w > 0) begin
                i_out_stall <= 1'b1;
                repeat (w) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin : stimulus
        logic [CH_W-1:0]     ch;
        logic [SAMPLE_W-1:0] smp;
        logic [CFG_W-1:0]    decay_val;
        logic [CFG_W-1:0]    alpha_val;
        logic [CFG_W-1:0]    hold_val;

        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_DECAY_FACTOR;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_channel   <= '0;
        i_sample    <= '0;
        i_out_stall <= 1'b0;
        quiet        = 1'b0;
        hold_off_req = 1'b0;
        samples_sent = 0;
        reg_writes   = 0;
        for (int c = 0; c < CHANNELS; c++) begin
            last_mag[c] = '0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with the reset register values. A zero sample on a
        // cleared channel equals both peaks and is not a new high; so is a
        // repeated full-scale value. 100 decays to 99 in one step, so 99
        // equals the decayed peak and -100 equals the held peak.
        send_sample(3'd0, 24'd0);
        send_sample(3'd0, FULL_POS);
        send_sample(3'd0, FULL_POS);
        send_sample(3'd0, FULL_NEG);
        send_sample(3'd0, 24'd0);
        send_sample(3'd1, 24'd100);
        send_sample(3'd1, 24'd99);
        send_sample(3'd1, -24'sd100);
        send_sample(3'd1, 24'd1);
        send_sample(3'd1, -24'sd1);
        send_sample(3'd7, -24'sd1);
        send_sample(3'd3, 24'h400000);
        send_sample(3'd3, 24'hC00000);
        send_sample(3'd2, 24'h555555);
        send_sample(3'd2, 24'hAAAAAA);
        wait_idle();

        // Zero hold length: a new high is held for no samples at all, so
        // decay resumes on the very next sample that is not a new high.
        // Both factors at their top value, and a write to the unused index.
        write_reg(CFG_HOLD_SAMPLES, 24'd0);
        write_reg(CFG_DECAY_FACTOR, 24'hFFFFFF);
        write_reg(CFG_RMS_ALPHA, 24'hFFFFFF);
        write_reg(CFG_UNUSED, 24'h123456);
        send_sample(3'd4, 24'd1000);
        send_sample(3'd4, 24'd500);
        send_sample(3'd4, 24'd500);
        send_sample(3'd4, 24'd500);
        send_sample(3'd5, FULL_NEG);
        send_sample(3'd5, FULL_POS);
        send_sample(3'd5, 24'd0);
        send_sample(3'd6, 24'h123456);
        send_sample(3'd6, -24'sh123456);
        wait_idle();

        // Random phases, each under its own register setting. The first
        // three pin the extremes; a hold written with all data bits set
        // checks that only the low 20 bits are kept.
        ch = '0;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    decay_val = '0;
                    alpha_val = 24'hFFFFFF;
                    hold_val  = '0;
                end
                1: begin
                    decay_val = 24'hFFFFFF;
                    alpha_val = '0;
                    hold_val  = 24'd1;
                end
                2: begin
                    decay_val = CFG_W'($urandom);
                    alpha_val = CFG_W'($urandom);
                    hold_val  = 24'hFFFFFF;
                end
                default: begin
                    decay_val = $urandom_range(0, 1)
                              ? CFG_W'($urandom)
                              : CFG_W'(24'hFFFFFF - $urandom_range(0, 4095));
                    alpha_val = CFG_W'($urandom);
                    hold_val  = CFG_W'($urandom_range(0, 40));
                end
            endcase
            write_reg(CFG_DECAY_FACTOR, decay_val);
            write_reg(CFG_RMS_ALPHA, alpha_val);
            write_reg(CFG_HOLD_SAMPLES, hold_val);
            if ($urandom_range(0, 1)) begin
                write_reg(CFG_UNUSED, CFG_W'($urandom));
            end

            // Two phases run with no idling on either side, and two others get the
            // long output hold-off.
            quiet        = (p == 2 || p == 6);
            hold_off_req = (p == 1 || p == 5);

            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // Half the time stay on the same channel, so that hold
                // countdowns run out and decay can be seen on one channel.
                if ($urandom_range(0, 1)) begin
                    ch = CH_W'($urandom_range(0, CHANNELS - 1));
                end
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: smp = SAMPLE_W'($urandom);
                    4, 5: smp = SAMPLE_W'($urandom_range(0, 255));
                    6: begin
                        case ($urandom_range(0, 3))
                            0:       smp = FULL_POS;
                            1:       smp = FULL_NEG;
                            2:       smp = '0;
                            default: smp = '1;
                        endcase
                    end
                    // Same magnitude as last time on this channel: often equal
                    // to the held peak, which must not count as a new high.
                    7: smp = last_mag[ch];
                    // A falling envelope, so the stored levels get to decay.
                    8: smp = last_mag[ch] - (last_mag[ch] >> 4);
                    default: begin
                        smp = SAMPLE_W'($urandom);
                        smp[SAMPLE_W-2] = ~smp[SAMPLE_W-1];
                    end
                endcase
                if ($urandom_range(0, 1)) begin
                    smp = -smp;
                end
                send_sample(ch, smp);
            end
            wait_idle();
        end
        quiet = 1'b0;

        $display("Summary: %0d samples over %0d channels, %0d level results compared,",
                 samples_sent, CHANNELS, results);
        $display("         %0d register writes across %0d settings.", reg_writes, PHASES + 2);
        if (fail_count == 0) begin
            $display("audio_peak_hold_rms_meter test passed");
        end else begin
            $display("audio_peak_hold_rms_meter test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/apm_pkg.sv
rtl/apm_ram.sv
rtl/apm_update.sv
rtl/audio_peak_hold_rms_meter.sv
tb/apm_level_checker.sv
tb/tb_audio_peak_hold_rms_meter.sv
